FILE: design/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// shared widths, codes and word types of the grid face connectivity generator
// ----------------------------------------------------------------------------
package gfc_pkg;

   // field widths
   localparam int CNT_W     = 11;   // cell count registers and csr data
   localparam int COORD_W   = 11;   // face coordinates
   localparam int AXIS_W    = 2;    // normal axis code
   localparam int CSR_IDX_W = 2;    // register index
   localparam int WORD_W    = 32;   // internal id arithmetic, modulo 2^32
   localparam int FACE_W    = 32;   // face id
   localparam int CELL_W    = 30;   // cell ids
   localparam int VERT_W    = 31;   // vertex ids
   localparam int SLOT_W    = 3;    // face slot of a cell

   localparam int DEFAULT_MAX_CELLS = 1024;

   // normal axis codes, the fourth code is an illegal request
   typedef enum logic [AXIS_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X   = 2'd0,
      CSR_CELLS_Y   = 2'd1,
      CSR_CELLS_Z   = 2'd2,
      CSR_THREE_DIM = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [AXIS_W-1:0]  normal_axis;
      logic [COORD_W-1:0] coord_i;
      logic [COORD_W-1:0] coord_j;
      logic [COORD_W-1:0] coord_k;
   } req_word_type;

   typedef struct packed {
      logic [FACE_W-1:0] face_id;
      logic [CELL_W-1:0] owner_cell;
      logic [SLOT_W-1:0] owner_face;
      logic              has_neighbour;
      logic [CELL_W-1:0] neighbour_cell;
      logic [SLOT_W-1:0] neighbour_face;
      logic [VERT_W-1:0] corner_zero;
      logic [VERT_W-1:0] corner_one;
      logic [VERT_W-1:0] corner_two;
      logic [VERT_W-1:0] corner_three;
      logic              bad_request;
   } rsp_word_type;

endpackage

FILE: design/gfc_if.sv
// ----------------------------------------------------------------------------
// gfc channel interfaces
// valid/ready channels carrying face requests and connectivity responses
// ----------------------------------------------------------------------------
interface gfc_req_if
   import gfc_pkg::*;
;
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gfc_rsp_if
   import gfc_pkg::*;
;
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/grid_face_connectivity_generator.sv
// ----------------------------------------------------------------------------
// grid_face_connectivity_generator
// face id, owner/neighbour cells and corner vertex ids of a cartesian grid face
// ----------------------------------------------------------------------------
// usage
//   req_ch  : request words (normal axis and face coordinates i, j, k)
//   rsp_ch  : one response word per request, in request order
//   csr_*   : write-only register port, index 0..2 cell counts along x, y, z
//             (clamped to 1..MAX_CELLS_PER_AXIS), index 3 selects 3d mode
// timing
//   four register stages: a word accepted into stage 1 moves through stages 2
//   and 3 and is shown on rsp_ch from stage 4 on. one word per cycle is taken
//   and given when the receiver keeps up, every stage takes a new word each cycle
// stalls
//   each stage holds its word while the next one is full and stalled, so
//   bubbles are squeezed out and req_ch.ready stays high while any stage is
//   empty; nothing is dropped or repeated
// reset
//   synchronous: empties the pipe, cell counts go to 1 and the grid to 2d.
//   grid-size products are registered from the registers and face totals from them,
//   which the pipe depth covers, so a request may follow a register write directly
// ----------------------------------------------------------------------------
module grid_face_connectivity_generator
   import gfc_pkg::*;
#(
   parameter int MAX_CELLS_PER_AXIS = DEFAULT_MAX_CELLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   gfc_req_if.sink              req_ch,
   gfc_rsp_if.source            rsp_ch
);

   // clamp limit, wide enough for the top of the parameter range
   localparam int                 MAXC_W = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam logic [MAXC_W-1:0]  MAX_C  = MAXC_W'(MAX_CELLS_PER_AXIS);
   localparam int                 CMP_W  = (MAXC_W > CNT_W) ? MAXC_W : CNT_W;
   localparam int                 CP1_W  = CNT_W + 1;

   // stage words
   typedef struct packed {
      logic               bad;
      axis_type           axis;
      logic [COORD_W-1:0] c0;
      logic [COORD_W-1:0] c1;
      logic [COORD_W-1:0] c2;
      logic [COORD_W-1:0] o0;
      logic [COORD_W-1:0] o1;
      logic [COORD_W-1:0] o2;
      logic               low;
      logic               interior;
   } s1_type;

   typedef struct packed {
      logic               bad;
      axis_type           axis;
      logic [COORD_W-1:0] c0;
      logic [COORD_W-1:0] o0;
      logic               low;
      logic               interior;
      logic [WORD_W-1:0]  fx1;
      logic [WORD_W-1:0]  ff2;
      logic [WORD_W-1:0]  xo1;
      logic [WORD_W-1:0]  xyo2;
      logic [WORD_W-1:0]  xc1;
      logic [WORD_W-1:0]  xyc2;
      logic [WORD_W-1:0]  vc1;
      logic [WORD_W-1:0]  vxyc2;
   } s2_type;

   typedef struct packed {
      logic               bad;
      axis_type           axis;
      logic [COORD_W-1:0] c0;
      logic               low;
      logic               interior;
      logic [WORD_W-1:0]  local_id;
      logic [WORD_W-1:0]  offset;
      logic [WORD_W-1:0]  owner;
      logic [WORD_W-1:0]  nbr;
      logic [WORD_W-1:0]  vj0;
      logic [WORD_W-1:0]  vj1;
      logic [WORD_W-1:0]  vk0;
      logic [WORD_W-1:0]  vk1;
   } s3_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CMP_W'(v) > CMP_W'(MAX_C)) begin
         r = CNT_W'(MAX_C);
      end
      return r;
   endfunction

   // configuration registers
   logic [CNT_W-1:0] cells_x_ff, cells_y_ff, cells_z_ff;
   logic             three_dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff   <= CNT_W'(1);
         cells_y_ff   <= CNT_W'(1);
         cells_z_ff   <= CNT_W'(1);
         three_dim_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CELLS_X:   cells_x_ff   <= clamp_count(csr_wdata);
            CSR_CELLS_Y:   cells_y_ff   <= clamp_count(csr_wdata);
            CSR_CELLS_Z:   cells_z_ff   <= clamp_count(csr_wdata);
            CSR_THREE_DIM: three_dim_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // grid-size products, recomputed every cycle from the registers
   logic [CP1_W-1:0]  vx;          // vertices along x
   logic [CP1_W-1:0]  vy;          // vertices along y
   logic [CNT_W-1:0]  zdepth;
   logic [WORD_W-1:0] xy_ff, x1y_ff, xy1_ff, vxy_ff;
   logic [WORD_W-1:0] xy_in, x1y_in, xy1_in, vxy_in;
   logic [WORD_W-1:0] xcount_ff, ycount_ff;
   logic [WORD_W-1:0] xcount_in, ycount_in;

   always_comb begin
      vx        = CP1_W'(cells_x_ff) + CP1_W'(1);
      vy        = CP1_W'(cells_y_ff) + CP1_W'(1);
      zdepth    = three_dim_ff ? cells_z_ff : CNT_W'(1);
      xy_in     = WORD_W'(cells_x_ff) * WORD_W'(cells_y_ff);
      x1y_in    = WORD_W'(vx) * WORD_W'(cells_y_ff);
      xy1_in    = WORD_W'(cells_x_ff) * WORD_W'(vy);
      vxy_in    = WORD_W'(vx) * WORD_W'(vy);
      // faces normal to x and to y over the whole grid
      xcount_in = x1y_ff * WORD_W'(zdepth);
      ycount_in = xy1_ff * WORD_W'(zdepth);
   end

   always_ff @(posedge clock) begin
      xy_ff     <= xy_in;
      x1y_ff    <= x1y_in;
      xy1_ff    <= xy1_in;
      vxy_ff    <= vxy_in;
      xcount_ff <= xcount_in;
      ycount_ff <= ycount_in;
   end

   // pipe control: a stage loads when it is empty or its word moves on
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   always_comb begin
      s4_en = !s4_valid_ff || rsp_ch.ready;
      s3_en = !s3_valid_ff || s4_en;
      s2_en = !s2_valid_ff || s3_en;
      s1_en = !s1_valid_ff || s2_en;
   end

   assign req_ch.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_ch.valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: range checks, owner coordinates, boundary flags
   s1_type             s1_ff, s1_in;
   logic [COORD_W-1:0] c_axis;
   logic [CNT_W-1:0]   n_axis;
   logic [CP1_W-1:0]   lim0, lim1, lim2;

   always_comb begin
      s1_in.axis = axis_type'(req_ch.data.normal_axis);
      s1_in.c0   = req_ch.data.coord_i;
      s1_in.c1   = req_ch.data.coord_j;
      s1_in.c2   = req_ch.data.coord_k;

      // the coordinate along the normal may sit on the far boundary
      lim0 = CP1_W'(cells_x_ff) + CP1_W'(s1_in.axis == AXIS_X);
      lim1 = CP1_W'(cells_y_ff) + CP1_W'(s1_in.axis == AXIS_Y);
      lim2 = CP1_W'(cells_z_ff) + CP1_W'(s1_in.axis == AXIS_Z);

      case (s1_in.axis)
         AXIS_X: begin
            c_axis = s1_in.c0;
            n_axis = cells_x_ff;
         end
         AXIS_Y: begin
            c_axis = s1_in.c1;
            n_axis = cells_y_ff;
         end
         AXIS_Z: begin
            c_axis = s1_in.c2;
            n_axis = cells_z_ff;
         end
         default: begin
            c_axis = '0;
            n_axis = '0;
         end
      endcase

      s1_in.bad = (s1_in.axis != AXIS_X && s1_in.axis != AXIS_Y && s1_in.axis != AXIS_Z)
               || (!three_dim_ff && (s1_in.axis == AXIS_Z || s1_in.c2 != '0))
               || (CP1_W'(s1_in.c0) >= lim0)
               || (CP1_W'(s1_in.c1) >= lim1)
               || (three_dim_ff && CP1_W'(s1_in.c2) >= lim2);

      s1_in.low      = (c_axis == '0);
      s1_in.interior = !s1_in.low && (c_axis != COORD_W'(n_axis));

      // owner sits one cell below the face along the normal, except at the low side
      s1_in.o0 = s1_in.c0 - COORD_W'(s1_in.axis == AXIS_X && !s1_in.low);
      s1_in.o1 = s1_in.c1 - COORD_W'(s1_in.axis == AXIS_Y && !s1_in.low);
      s1_in.o2 = s1_in.c2 - COORD_W'(s1_in.axis == AXIS_Z && !s1_in.low);
   end

   always_ff @(posedge clock) begin
      if (s1_en) s1_ff <= s1_in;
   end

   // stage 2: multiply bank
   s2_type            s2_ff, s2_in;
   logic [CP1_W-1:0]  f0;          // face count along x for this normal
   logic [WORD_W-1:0] f01;         // faces per k layer for this normal

   always_comb begin
      f0 = CP1_W'(cells_x_ff) + CP1_W'(s1_ff.axis == AXIS_X);
      case (s1_ff.axis)
         AXIS_X:  f01 = x1y_ff;
         AXIS_Y:  f01 = xy1_ff;
         default: f01 = xy_ff;
      endcase

      s2_in.bad      = s1_ff.bad;
      s2_in.axis     = s1_ff.axis;
      s2_in.c0       = s1_ff.c0;
      s2_in.o0       = s1_ff.o0;
      s2_in.low      = s1_ff.low;
      s2_in.interior = s1_ff.interior;
      s2_in.fx1      = WORD_W'(f0) * WORD_W'(s1_ff.c1);
      s2_in.ff2      = f01 * WORD_W'(s1_ff.c2);
      s2_in.xo1      = WORD_W'(cells_x_ff) * WORD_W'(s1_ff.o1);
      s2_in.xyo2     = xy_ff * WORD_W'(s1_ff.o2);
      s2_in.xc1      = WORD_W'(cells_x_ff) * WORD_W'(s1_ff.c1);
      s2_in.xyc2     = xy_ff * WORD_W'(s1_ff.c2);
      s2_in.vc1      = WORD_W'(vx) * WORD_W'(s1_ff.c1);
      s2_in.vxyc2    = vxy_ff * WORD_W'(s1_ff.c2);
   end

   always_ff @(posedge clock) begin
      if (s2_en) s2_ff <= s2_in;
   end

   // stage 3: id sums and the per-axis offset
   s3_type s3_ff, s3_in;

   always_comb begin
      s3_in.bad      = s2_ff.bad;
      s3_in.axis     = s2_ff.axis;
      s3_in.c0       = s2_ff.c0;
      s3_in.low      = s2_ff.low;
      s3_in.interior = s2_ff.interior;
      s3_in.local_id = WORD_W'(s2_ff.c0) + s2_ff.fx1 + s2_ff.ff2;
      s3_in.owner    = WORD_W'(s2_ff.o0) + s2_ff.xo1 + s2_ff.xyo2;
      s3_in.nbr      = WORD_W'(s2_ff.c0) + s2_ff.xc1 + s2_ff.xyc2;
      // x faces first, then y faces, then z faces
      case (s2_ff.axis)
         AXIS_X:  s3_in.offset = '0;
         AXIS_Y:  s3_in.offset = xcount_ff;
         default: s3_in.offset = xcount_ff + ycount_ff;
      endcase
      // vertex row and layer terms, without and with the +1 step
      s3_in.vj0 = s2_ff.vc1;
      s3_in.vj1 = s2_ff.vc1 + WORD_W'(vx);
      s3_in.vk0 = s2_ff.vxyc2;
      s3_in.vk1 = s2_ff.vxyc2 + vxy_ff;
   end

   always_ff @(posedge clock) begin
      if (s3_en) s3_ff <= s3_in;
   end

   // stage 4: face id, corners, response word
   rsp_word_type      s4_ff, s4_in;
   logic [WORD_W-1:0] i0, i1;
   logic [WORD_W-1:0] face_sum;
   logic [WORD_W-1:0] cor0, cor1, cor2, cor3;

   always_comb begin
      i0       = WORD_W'(s3_ff.c0);
      i1       = WORD_W'(s3_ff.c0) + WORD_W'(1);
      face_sum = s3_ff.offset + s3_ff.local_id;
      cor0     = i0 + s3_ff.vj0 + s3_ff.vk0;

      case (s3_ff.axis)
         AXIS_X: begin
            cor1 = i0 + s3_ff.vj1 + s3_ff.vk0;
            cor2 = i0 + s3_ff.vj1 + s3_ff.vk1;
            cor3 = i0 + s3_ff.vj0 + s3_ff.vk1;
         end
         AXIS_Y: begin
            cor1 = i1 + s3_ff.vj0 + s3_ff.vk0;
            cor2 = i1 + s3_ff.vj0 + s3_ff.vk1;
            cor3 = i0 + s3_ff.vj0 + s3_ff.vk1;
         end
         default: begin
            cor1 = i1 + s3_ff.vj0 + s3_ff.vk0;
            cor2 = i1 + s3_ff.vj1 + s3_ff.vk0;
            cor3 = i0 + s3_ff.vj1 + s3_ff.vk0;
         end
      endcase

      // a 2d face is an edge with two corners (z normals never pass the checks)
      if (!three_dim_ff) begin
         cor2 = '0;
         cor3 = '0;
      end

      s4_in.face_id        = face_sum[FACE_W-1:0];
      s4_in.owner_cell     = s3_ff.owner[CELL_W-1:0];
      s4_in.owner_face     = {s3_ff.axis, s3_ff.low};
      s4_in.has_neighbour  = s3_ff.interior;
      s4_in.neighbour_cell = s3_ff.interior ? s3_ff.nbr[CELL_W-1:0] : '0;
      s4_in.neighbour_face = s3_ff.interior ? {s3_ff.axis, 1'b1} : '0;
      s4_in.corner_zero    = cor0[VERT_W-1:0];
      s4_in.corner_one     = cor1[VERT_W-1:0];
      s4_in.corner_two     = cor2[VERT_W-1:0];
      s4_in.corner_three   = cor3[VERT_W-1:0];
      s4_in.bad_request    = 1'b0;

      // rejected request: everything zero but the flag
      if (s3_ff.bad) begin
         s4_in             = '0;
         s4_in.bad_request = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) s4_ff <= s4_in;
   end

   assign rsp_ch.valid = s4_valid_ff;
   assign rsp_ch.data  = s4_ff;

endmodule
